// ===== hw/rtl/mbrm_pkg.sv =====
// shared types and constants of the modbus rtu register read master
`default_nettype none

package mbrm_pkg;

   // operation codes of an incoming word
   localparam logic [1:0] OP_SEND = 2'd0;
   localparam logic [1:0] OP_BYTE = 2'd1;
   localparam logic [1:0] OP_TICK = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_TX     = 2'd0;
   localparam logic [1:0] KIND_REG    = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   // status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_CRC     = 2'd1;
   localparam logic [1:0] STATUS_TIMEOUT = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_SLAVE_ADDRESS = 2'd0;
   localparam logic [1:0] CSR_FUNC_ID       = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT_TICKS = 2'd2;

   // configuration reset values
   localparam logic [7:0]  SLAVE_ADDRESS_RST = 8'h01;
   localparam logic [7:0]  FUNC_ID_RST       = 8'h03;
   localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd10000;

   // crc-16/modbus
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // frame layout
   localparam logic [2:0] TX_CRC_LOW  = 3'd6;
   localparam logic [2:0] TX_CRC_HIGH = 3'd7;

   typedef struct packed {
      logic       start_req;
      logic       tx_load;
      logic       crc_shift;
      logic       rx_take;
      logic       tick_take;
      logic       reg_load;
      logic       stat_load;
      logic [1:0] stat_code;
   } mbrm_cmd_type;

   typedef struct packed {
      logic [2:0] tx_idx;
      logic       bit_done;
      logic       out_free;
      logic       rx_data;
      logic       rx_final;
      logic       crc_good;
      logic       tick_expire;
      logic       reg_last;
   } mbrm_stat_type;

endpackage

`default_nettype wire

// ===== hw/rtl/mbrm_ifs.sv =====
// valid/ready channel interfaces of the request, response and csr ports
`default_nettype none

interface mbrm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [15:0] start_address;
   logic [3:0]  register_count;
   logic [7:0]  rx_byte;

   modport source (output valid, operation, start_address, register_count, rx_byte,
                   input ready);
   modport sink   (input valid, operation, start_address, register_count, rx_byte,
                   output ready);
endinterface

interface mbrm_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [15:0] value;
   logic [2:0]  register_index;
   logic [1:0]  status;
   logic        last;

   modport source (output valid, kind, value, register_index, status, last,
                   input ready);
   modport sink   (input valid, kind, value, register_index, status, last,
                   output ready);
endinterface

interface mbrm_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  addr;
   logic [15:0] data;

   modport source (output valid, addr, data, input ready);
   modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mbrm_datapath.sv =====
// datapath: csr registers, crc unit, frame tracking, register buffer, output register
`default_nettype none

module mbrm_datapath #(
   parameter int MAX_REGISTERS = 8
) (
   input  wire                    clock,
   input  wire                    reset,
   input  mbrm_pkg::mbrm_cmd_type cmd,
   output mbrm_pkg::mbrm_stat_type stat,
   input  wire  [15:0]            req_start_address,
   input  wire  [3:0]             req_register_count,
   input  wire  [7:0]             req_rx_byte,
   input  wire                    csr_write,
   input  wire  [1:0]             csr_addr,
   input  wire  [15:0]            csr_data,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output logic [1:0]             rsp_kind,
   output logic [15:0]            rsp_value,
   output logic [2:0]             rsp_register_index,
   output logic [1:0]             rsp_status,
   output logic                   rsp_last
);
   import mbrm_pkg::*;

   localparam int REG_LIMIT = (MAX_REGISTERS < 8) ? MAX_REGISTERS : 8;
   localparam int IDX_W     = (REG_LIMIT > 1) ? $clog2(REG_LIMIT) : 1;
   localparam logic [3:0] LIMIT_C = 4'(REG_LIMIT);

   // configuration
   logic [7:0]  slave_ff, slave_in;
   logic [7:0]  func_ff, func_in;
   logic [15:0] timeout_ff, timeout_in;

   // request and reply tracking
   logic [15:0] addr_ff, addr_in;
   logic [3:0]  count_ff, count_in;
   logic [2:0]  tx_idx_ff, tx_idx_in;
   logic [2:0]  bit_ff, bit_in;
   logic [15:0] crc_ff, crc_in;
   logic        awaiting_ff, awaiting_in;
   logic [4:0]  pos_ff, pos_in;
   logic [7:0]  hold_ff, hold_in;
   logic [7:0]  crc_low_ff, crc_low_in;
   logic [15:0] wait_ff, wait_in;
   logic [IDX_W-1:0] rd_ff, rd_in;

   // register buffer
   logic [15:0] buf_ff [REG_LIMIT];
   logic        buf_we;
   logic [IDX_W-1:0] buf_wi;

   // output register
   logic        valid_ff, valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [15:0] value_ff, value_in;
   logic [2:0]  index_ff, index_in;
   logic [1:0]  status_ff, status_in;
   logic        last_ff, last_in;

   logic [3:0]  count_clamped;
   logic [7:0]  tx_byte;
   logic [4:0]  data_end;
   logic [4:0]  offset;
   logic        mismatch;
   logic [15:0] wait_next;
   logic        out_free;

   always_comb begin
      if (req_register_count == 4'd0) begin
         count_clamped = 4'd1;
      end else if (req_register_count > LIMIT_C) begin
         count_clamped = LIMIT_C;
      end else begin
         count_clamped = req_register_count;
      end
   end

   always_comb begin
      case (tx_idx_ff)
         3'd0:    tx_byte = slave_ff;
         3'd1:    tx_byte = func_ff;
         3'd2:    tx_byte = addr_ff[15:8];
         3'd3:    tx_byte = addr_ff[7:0];
         3'd4:    tx_byte = 8'h00;
         3'd5:    tx_byte = {4'h0, count_ff};
         3'd6:    tx_byte = crc_ff[7:0];
         default: tx_byte = crc_ff[15:8];
      endcase
   end

   assign data_end  = 5'd3 + {count_ff, 1'b0};
   assign offset    = pos_ff - 5'd3;
   assign mismatch  = ((pos_ff == 5'd0) && (req_rx_byte != slave_ff)) ||
                      ((pos_ff == 5'd1) && (req_rx_byte != func_ff));
   assign wait_next = (wait_ff == 16'hFFFF) ? wait_ff : wait_ff + 16'd1;
   assign out_free  = !valid_ff || rsp_ready;

   always_comb begin
      stat.tx_idx      = tx_idx_ff;
      stat.bit_done    = (bit_ff == 3'd7);
      stat.out_free    = out_free;
      stat.rx_data     = awaiting_ff && !mismatch && (pos_ff < data_end);
      stat.rx_final    = awaiting_ff && (pos_ff > data_end);
      stat.crc_good    = (crc_low_ff == crc_ff[7:0]) && (req_rx_byte == crc_ff[15:8]);
      stat.tick_expire = awaiting_ff && (wait_next >= timeout_ff);
      stat.reg_last    = ((4'(rd_ff) + 4'd1) == count_ff);
   end

   always_comb begin
      slave_in    = slave_ff;
      func_in     = func_ff;
      timeout_in  = timeout_ff;
      addr_in     = addr_ff;
      count_in    = count_ff;
      tx_idx_in   = tx_idx_ff;
      bit_in      = bit_ff;
      crc_in      = crc_ff;
      awaiting_in = awaiting_ff;
      pos_in      = pos_ff;
      hold_in     = hold_ff;
      crc_low_in  = crc_low_ff;
      wait_in     = wait_ff;
      rd_in       = rd_ff;
      buf_we      = 1'b0;
      buf_wi      = offset[IDX_W:1];
      valid_in    = valid_ff && !rsp_ready;
      kind_in     = kind_ff;
      value_in    = value_ff;
      index_in    = index_ff;
      status_in   = status_ff;
      last_in     = last_ff;

      if (csr_write) begin
         unique case (csr_addr)
            CSR_SLAVE_ADDRESS: slave_in   = csr_data[7:0];
            CSR_FUNC_ID:       func_in    = csr_data[7:0];
            CSR_TIMEOUT_TICKS: timeout_in = csr_data;
            default: ;
         endcase
      end

      if (cmd.start_req) begin
         addr_in     = req_start_address;
         count_in    = count_clamped;
         tx_idx_in   = 3'd0;
         crc_in      = CRC_INIT;
         awaiting_in = 1'b1;
         pos_in      = 5'd0;
         hold_in     = 8'h00;
         crc_low_in  = 8'h00;
         wait_in     = 16'd0;
      end

      if (cmd.tx_load) begin
         if (tx_idx_ff < TX_CRC_LOW) begin
            crc_in = crc_ff ^ {8'h00, tx_byte};
         end else if (tx_idx_ff == TX_CRC_HIGH) begin
            crc_in = CRC_INIT;
         end
         tx_idx_in = tx_idx_ff + 3'd1;
         valid_in  = 1'b1;
         kind_in   = KIND_TX;
         value_in  = {8'h00, tx_byte};
         index_in  = 3'd0;
         status_in = STATUS_OK;
         last_in   = (tx_idx_ff == TX_CRC_HIGH);
      end

      // one bit of crc-16/modbus per cycle
      if (cmd.crc_shift) begin
         crc_in = crc_ff[0] ? ((crc_ff >> 1) ^ CRC_POLY) : (crc_ff >> 1);
         bit_in = bit_ff + 3'd1;
      end

      if (cmd.rx_take && awaiting_ff) begin
         if (mismatch) begin
            pos_in = 5'd0;
            crc_in = CRC_INIT;
         end else if (pos_ff < data_end) begin
            crc_in = crc_ff ^ {8'h00, req_rx_byte};
            if (pos_ff >= 5'd3) begin
               if (!offset[0]) begin
                  hold_in = req_rx_byte;
               end else begin
                  buf_we = 1'b1;
               end
            end
            pos_in = pos_ff + 5'd1;
         end else if (pos_ff == data_end) begin
            crc_low_in = req_rx_byte;
            pos_in     = pos_ff + 5'd1;
         end else begin
            awaiting_in = 1'b0;
            pos_in      = 5'd0;
            crc_in      = CRC_INIT;
            rd_in       = '0;
         end
      end

      if (cmd.tick_take && awaiting_ff) begin
         wait_in = wait_next;
         if (stat.tick_expire) begin
            awaiting_in = 1'b0;
            pos_in      = 5'd0;
            crc_in      = CRC_INIT;
         end
      end

      if (cmd.reg_load) begin
         rd_in     = stat.reg_last ? '0 : rd_ff + 1'b1;
         valid_in  = 1'b1;
         kind_in   = KIND_REG;
         value_in  = buf_ff[rd_ff];
         index_in  = 3'(rd_ff);
         status_in = STATUS_OK;
         last_in   = stat.reg_last;
      end

      if (cmd.stat_load) begin
         valid_in  = 1'b1;
         kind_in   = KIND_STATUS;
         value_in  = 16'd0;
         index_in  = 3'd0;
         status_in = cmd.stat_code;
         last_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_ff    <= SLAVE_ADDRESS_RST;
         func_ff     <= FUNC_ID_RST;
         timeout_ff  <= TIMEOUT_TICKS_RST;
         count_ff    <= 4'd0;
         tx_idx_ff   <= 3'd0;
         bit_ff      <= 3'd0;
         crc_ff      <= CRC_INIT;
         awaiting_ff <= 1'b0;
         pos_ff      <= 5'd0;
         hold_ff     <= 8'h00;
         crc_low_ff  <= 8'h00;
         wait_ff     <= 16'd0;
         rd_ff       <= '0;
         valid_ff    <= 1'b0;
      end else begin
         slave_ff    <= slave_in;
         func_ff     <= func_in;
         timeout_ff  <= timeout_in;
         count_ff    <= count_in;
         tx_idx_ff   <= tx_idx_in;
         bit_ff      <= bit_in;
         crc_ff      <= crc_in;
         awaiting_ff <= awaiting_in;
         pos_ff      <= pos_in;
         hold_ff     <= hold_in;
         crc_low_ff  <= crc_low_in;
         wait_ff     <= wait_in;
         rd_ff       <= rd_in;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff   <= addr_in;
      kind_ff   <= kind_in;
      value_ff  <= value_in;
      index_ff  <= index_in;
      status_ff <= status_in;
      last_ff   <= last_in;
      if (buf_we) begin
         buf_ff[buf_wi] <= {hold_ff, req_rx_byte};
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_value          = value_ff;
   assign rsp_register_index = index_ff;
   assign rsp_status         = status_ff;
   assign rsp_last           = last_ff;

`ifndef ASSERT_OFF
   // a result is only loaded into a free output register
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.tx_load || cmd.reg_load || cmd.stat_load) |-> out_free)
      else $error("result loaded over a pending word");

   // the crc is back at its seed once the frame crc high byte has gone out
   a_crc_reseed: assert property (@(posedge clock) disable iff (reset)
      (cmd.tx_load && (tx_idx_ff == TX_CRC_HIGH)) |=> (crc_ff == CRC_INIT))
      else $error("crc not reseeded after request frame");

   // a timeout ends the wait
   a_timeout_ends_wait: assert property (@(posedge clock) disable iff (reset)
      (cmd.tick_take && stat.tick_expire) |=> !awaiting_ff)
      else $error("reply still awaited after timeout");

   // reception never runs past the crc high byte
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      awaiting_ff |-> (pos_ff <= (data_end + 5'd1)))
      else $error("byte position beyond end of reply");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/mbrm_ctrl.sv =====
// controller: sequences request frames, crc bit steps and reply release
`default_nettype none

module mbrm_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   input  wire  [1:0]              req_operation,
   output logic                    req_ready,
   output mbrm_pkg::mbrm_cmd_type  cmd,
   input  mbrm_pkg::mbrm_stat_type stat
);
   import mbrm_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_TX_LOAD = 6'b000010,
      S_TX_CRC  = 6'b000100,
      S_RX_CRC  = 6'b001000,
      S_REG_OUT = 6'b010000,
      S_STAT    = 6'b100000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] code_ff, code_in;
   logic       accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in      = state_ff;
      code_in       = code_ff;
      cmd           = '0;
      cmd.stat_code = code_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_operation)
                  OP_SEND: begin
                     cmd.start_req = 1'b1;
                     state_in      = S_TX_LOAD;
                  end
                  OP_BYTE: begin
                     cmd.rx_take = 1'b1;
                     if (stat.rx_data) begin
                        state_in = S_RX_CRC;
                     end else if (stat.rx_final) begin
                        if (stat.crc_good) begin
                           state_in = S_REG_OUT;
                        end else begin
                           code_in  = STATUS_CRC;
                           state_in = S_STAT;
                        end
                     end
                  end
                  OP_TICK: begin
                     cmd.tick_take = 1'b1;
                     if (stat.tick_expire) begin
                        code_in  = STATUS_TIMEOUT;
                        state_in = S_STAT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_TX_LOAD: begin
            if (stat.out_free) begin
               cmd.tx_load = 1'b1;
               if (stat.tx_idx < TX_CRC_LOW) begin
                  state_in = S_TX_CRC;
               end else if (stat.tx_idx == TX_CRC_HIGH) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_TX_CRC: begin
            cmd.crc_shift = 1'b1;
            if (stat.bit_done) begin
               state_in = S_TX_LOAD;
            end
         end
         S_RX_CRC: begin
            cmd.crc_shift = 1'b1;
            if (stat.bit_done) begin
               state_in = S_IDLE;
            end
         end
         S_REG_OUT: begin
            if (stat.out_free) begin
               cmd.reg_load = 1'b1;
               if (stat.reg_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_STAT: begin
            if (stat.out_free) begin
               cmd.stat_load = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         code_ff  <= STATUS_OK;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

`ifndef ASSERT_OFF
   // at most one result source per cycle
   a_one_load: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.tx_load, cmd.reg_load, cmd.stat_load}) <= 1)
      else $error("two result loads in one cycle");

   // crc stepping and new input never overlap
   a_shift_blocks_input: assert property (@(posedge clock) disable iff (reset)
      cmd.crc_shift |-> !req_ready)
      else $error("input taken during crc stepping");

   // a status word always reports a failure
   a_stat_code: assert property (@(posedge clock) disable iff (reset)
      cmd.stat_load |-> ((cmd.stat_code == STATUS_CRC) || (cmd.stat_code == STATUS_TIMEOUT)))
      else $error("status word without failure code");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/modbus_rtu_register_read_master_top.sv =====
// top level of the modbus rtu register read master
`default_nettype none

// Modbus RTU read-holding-registers master. A request word (operation send)
// produces the eight-byte frame slave id, function code, start address high
// and low, count high (zero) and low, then CRC-16/Modbus low byte first, as
// eight transmit words with last on the final one. Received byte words are
// matched against the configured slave id and function byte (a mismatch drops
// the frame and reception restarts), folded into the running crc, and after
// 5 + 2*count bytes a good crc releases the register values in order
// (big-endian, last on the final one) while a bad crc gives one status word
// with status crc mismatch. Tick words count towards timeout_ticks while a
// reply is awaited; on expiry one status word with status timeout is given.
// Bytes and ticks while nothing is awaited, and unknown operations, give no
// word.
// Sequencing: the crc advances one bit per cycle, so a received frame byte is
// accepted and then takes eight crc steps; a request is accepted, then each
// of six bytes takes one load and eight crc steps, then the two crc bytes are
// loaded, any load waiting while the output is stalled; ticks, id mismatches
// and the crc low byte take no crc steps; the byte that completes a reply and
// a tick that expires are followed by one load per result word. The request
// channel is ready only while the controller is idle. The configuration port
// is always ready; write it only while no reply is being emitted.
// MAX_REGISTERS sizes the register buffer; counts are clamped to 1 and to
// the lesser of MAX_REGISTERS and 8.

module modbus_rtu_register_read_master_top #(
   parameter int MAX_REGISTERS = 8
) (
   input wire        clock,
   input wire        reset,
   mbrm_req_if.sink  req_bus,
   mbrm_rsp_if.source rsp_bus,
   mbrm_csr_if.sink  csr_bus
);
   import mbrm_pkg::*;

   mbrm_cmd_type  cmd;
   mbrm_stat_type stat;
   logic          csr_write;

   // configuration writes are registered directly, no back pressure
   assign csr_bus.ready = 1'b1;
   assign csr_write     = csr_bus.valid;

   // controller: decodes each accepted word and sequences the datapath
   mbrm_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_bus.valid),
      .req_operation (req_bus.operation),
      .req_ready     (req_bus.ready),
      .cmd           (cmd),
      .stat          (stat)
   );

   // datapath: crc unit, frame counters, register buffer and output register
   mbrm_datapath #(
      .MAX_REGISTERS (MAX_REGISTERS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_start_address  (req_bus.start_address),
      .req_register_count (req_bus.register_count),
      .req_rx_byte        (req_bus.rx_byte),
      .csr_write          (csr_write),
      .csr_addr           (csr_bus.addr),
      .csr_data           (csr_bus.data),
      .rsp_valid          (rsp_bus.valid),
      .rsp_ready          (rsp_bus.ready),
      .rsp_kind           (rsp_bus.kind),
      .rsp_value          (rsp_bus.value),
      .rsp_register_index (rsp_bus.register_index),
      .rsp_status         (rsp_bus.status),
      .rsp_last           (rsp_bus.last)
   );

endmodule

`default_nettype wire

// ===== tb/tb_modbus_rtu_register_read_master_top.sv =====
// self-checking testbench of the modbus rtu register read master top level
`default_nettype none

module tb_modbus_rtu_register_read_master_top;
   import mbrm_pkg::*;

   localparam int MAX_REGS   = 8;
   localparam int REG_LIMIT  = (MAX_REGS < 8) ? MAX_REGS : 8;
   // longest legal quiet stretch is the receiver hold-off plus a request in flight
   localparam int IDLE_LIMIT = 3000;
   // cycles to let a word that gives no result drain through the crc engine
   localparam int SETTLE     = 64;
   localparam int SQUEEZE    = 600;
   localparam int RAND_WORDS = 30;
   localparam logic [1:0] OP_UNKNOWN = 2'd3;
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] value;
      logic [2:0]  register_index;
      logic [1:0]  status;
      logic        last;
   } result_t;

   // predicts the master's output words and checks the ones the block emits
   class frame_scoreboard;
      logic [7:0]  slave_addr;
      logic [7:0]  func_id;
      logic [15:0] timeout_ticks;
      logic        awaiting;
      logic [3:0]  exp_regs;
      logic [4:0]  byte_pos;
      logic [15:0] crc;
      logic [15:0] reg_buf [MAX_REGS];
      logic [7:0]  high_hold;
      logic [7:0]  crc_low;
      logic [15:0] wait_cnt;
      result_t     expected_q [$];
      int          failures;

      function new();
         slave_addr    = SLAVE_ADDRESS_RST;
         func_id       = FUNC_ID_RST;
         timeout_ticks = TIMEOUT_TICKS_RST;
         awaiting      = 1'b0;
         exp_regs      = '0;
         byte_pos      = '0;
         crc           = CRC_INIT;
         high_hold     = '0;
         crc_low       = '0;
         wait_cnt      = '0;
         failures      = 0;
         foreach (reg_buf[i]) reg_buf[i] = '0;
      endfunction

      function logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
         logic [15:0] r;
         r = c ^ {8'h00, b};
         for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
         return r;
      endfunction

      function int clamp_count(input logic [3:0] cnt);
         if (cnt == 4'd0) return 1;
         if (int'(cnt) > REG_LIMIT) return REG_LIMIT;
         return int'(cnt);
      endfunction

      function void push(input logic [1:0] kind, input logic [15:0] value,
                         input logic [2:0] idx, input logic [1:0] status,
                         input logic last);
         result_t r;
         r.kind           = kind;
         r.value          = value;
         r.register_index = idx;
         r.status         = status;
         r.last           = last;
         expected_q.push_back(r);
      endfunction

      function void set_register(input logic [1:0] idx, input logic [15:0] data);
         case (idx)
            CSR_SLAVE_ADDRESS: slave_addr = data[7:0];
            CSR_FUNC_ID: func_id = data[7:0];
            CSR_TIMEOUT_TICKS: timeout_ticks = data;
            default: ;
         endcase
      endfunction

      function void note_input(input logic [1:0] op, input logic [15:0] addr,
                               input logic [3:0] cnt, input logic [7:0] rxb);
         logic [7:0]  frame [8];
         logic [15:0] c;
         int          n;
         int          pos;
         int          data_end;
         int          off;
         bit          good;
         case (op)
            OP_SEND: begin
               n = clamp_count(cnt);
               frame[0] = slave_addr;
               frame[1] = func_id;
               frame[2] = addr[15:8];
               frame[3] = addr[7:0];
               frame[4] = 8'h00;
               frame[5] = 8'(n);
               c = CRC_INIT;
               for (int i = 0; i < 6; i++) c = crc_byte(c, frame[i]);
               frame[6] = c[7:0];
               frame[7] = c[15:8];
               for (int i = 0; i < 8; i++)
                  push(KIND_TX, {8'h00, frame[i]}, 3'd0, STATUS_OK, i == 7);
               // a new request abandons whatever reply was pending
               awaiting  = 1'b1;
               exp_regs  = 4'(n);
               byte_pos  = '0;
               crc       = CRC_INIT;
               high_hold = '0;
               crc_low   = '0;
               wait_cnt  = '0;
            end
            OP_BYTE: if (awaiting) begin
               n        = clamp_count(exp_regs);
               data_end = 3 + 2 * n;
               pos      = int'(byte_pos);
               if ((pos == 0 && rxb != slave_addr) || (pos == 1 && rxb != func_id)) begin
                  // wrong id drops the frame, timeout keeps running
                  byte_pos = '0;
                  crc      = CRC_INIT;
               end else if (pos < data_end) begin
                  crc = crc_byte(crc, rxb);
                  if (pos >= 3) begin
                     off = pos - 3;
                     if (off % 2 == 0) high_hold = rxb;
                     else reg_buf[(off / 2) % MAX_REGS] = {high_hold, rxb};
                  end
                  byte_pos = 5'(pos + 1);
               end else if (pos == data_end) begin
                  crc_low  = rxb;
                  byte_pos = 5'(pos + 1);
               end else begin
                  awaiting = 1'b0;
                  good     = (crc_low == crc[7:0]) && (rxb == crc[15:8]);
                  byte_pos = '0;
                  crc      = CRC_INIT;
                  if (good) begin
                     for (int i = 0; i < n; i++)
                        push(KIND_REG, reg_buf[i % MAX_REGS], 3'(i), STATUS_OK, i + 1 == n);
                  end else begin
                     push(KIND_STATUS, 16'd0, 3'd0, STATUS_CRC, 1'b1);
                  end
               end
            end
            OP_TICK: if (awaiting) begin
               if (wait_cnt != 16'hFFFF) wait_cnt = wait_cnt + 16'd1;
               if (wait_cnt >= timeout_ticks) begin
                  awaiting = 1'b0;
                  byte_pos = '0;
                  crc      = CRC_INIT;
                  push(KIND_STATUS, 16'd0, 3'd0, STATUS_TIMEOUT, 1'b1);
               end
            end
            default: ;
         endcase
      endfunction

      task report(input string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         failures++;
      endtask

      task check_result(input logic [1:0] kind, input logic [15:0] value,
                        input logic [2:0] idx, input logic [1:0] status, input logic last);
         result_t want;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected word kind %0d value %h", kind, value));
            return;
         end
         want = expected_q.pop_front();
         if (kind !== want.kind)
            report($sformatf("kind %0d, want %0d", kind, want.kind));
         if (value !== want.value)
            report($sformatf("value %h, want %h", value, want.value));
         if (idx !== want.register_index)
            report($sformatf("register_index %0d, want %0d", idx, want.register_index));
         if (status !== want.status)
            report($sformatf("status %0d, want %0d", status, want.status));
         if (last !== want.last)
            report($sformatf("last %0d, want %0d", last, want.last));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   mbrm_req_if req_bus ();
   mbrm_rsp_if rsp_bus ();
   mbrm_csr_if csr_bus ();

   modbus_rtu_register_read_master_top #(
      .MAX_REGISTERS(MAX_REGS)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   frame_scoreboard sb;

   int  send_calm;
   int  recv_calm;
   int  words_counted;
   int  stalled_cycles;
   bit  no_gaps;
   bit  squeeze_pending;

   always #2 clock = ~clock;

   // idle cycles before the next word: mostly random, sometimes a stretch of none
   function automatic int draw_idle(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(10, 30);
         return 0;
      end
      return $urandom_range(0, 19);
   endfunction

   // offer one word; valid stays high into the next word when no gap is drawn
   task automatic send_word(input logic [1:0] op, input logic [15:0] addr,
                            input logic [3:0] cnt, input logic [7:0] rxb);
      int gap;
      gap = no_gaps ? 0 : draw_idle(send_calm);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.operation      <= op;
      req_bus.start_address  <= addr;
      req_bus.register_count <= cnt;
      req_bus.rx_byte        <= rxb;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      // words while nothing is awaited, other than requests, are not counted
      if (op == OP_SEND || sb.awaiting) words_counted++;
      sb.note_input(op, addr, cnt, rxb);
   endtask

   task automatic send_request(input logic [15:0] addr, input logic [3:0] cnt);
      send_word(OP_SEND, addr, cnt, 8'($urandom));
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_word(OP_BYTE, 16'($urandom), 4'($urandom), b);
   endtask

   task automatic send_tick();
      send_word(OP_TICK, 16'($urandom), 4'($urandom), 8'($urandom));
   endtask

   // reply frame from the slave side; keep < 0 sends it whole
   task automatic send_reply(input int n, input bit corrupt, input bit noisy,
                             input bit tick_mix, input int keep);
      logic [7:0]  frame_bytes [$];
      logic [15:0] c;
      logic [7:0]  b;
      frame_bytes.push_back(sb.slave_addr);
      frame_bytes.push_back(sb.func_id);
      // the byte count is not checked by the block, so it is sometimes wrong
      frame_bytes.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'(2 * n));
      for (int i = 0; i < 2 * n; i++) frame_bytes.push_back(8'($urandom));
      c = CRC_INIT;
      foreach (frame_bytes[i]) c = sb.crc_byte(c, frame_bytes[i]);
      if (corrupt) c = c ^ (16'h0001 << $urandom_range(0, 15));
      frame_bytes.push_back(c[7:0]);
      frame_bytes.push_back(c[15:8]);
      if (noisy) begin
         b = 8'($urandom);
         if ($urandom_range(0, 1) == 1) begin
            // right slave id followed by a wrong function code
            send_byte(sb.slave_addr);
            if (b == sb.func_id) b = ~b;
         end else begin
            if (b == sb.slave_addr) b = ~b;
         end
         send_byte(b);
      end
      foreach (frame_bytes[i]) begin
         if (keep >= 0 && i >= keep) break;
         if (tick_mix && $urandom_range(0, 3) == 0) send_tick();
         send_byte(frame_bytes[i]);
      end
   endtask

   // drop valid, let every expected word arrive, then let the crc engine drain
   task automatic quiesce();
      req_bus.valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.addr  <= idx;
      csr_bus.data  <= data;
      do @(posedge clock); while (!(csr_bus.valid && csr_bus.ready));
      sb.set_register(idx, data);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic configure(input logic [15:0] slave, input logic [15:0] func,
                            input logic [15:0] ticks);
      quiesce();
      write_csr(CSR_SLAVE_ADDRESS, slave);
      write_csr(CSR_FUNC_ID, func);
      write_csr(CSR_TIMEOUT_TICKS, ticks);
   endtask

   // mostly well-formed request/reply exchanges, the rest ticks and noise
   task automatic random_sequence();
      int         pick;
      int         keep;
      logic [3:0] cnt;
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
         cnt = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(1, REG_LIMIT));
         keep = -1;
         if ($urandom_range(0, 7) == 0) keep = $urandom_range(0, 2 * REG_LIMIT + 4);
         send_request(16'($urandom), cnt);
         send_reply(sb.clamp_count(cnt), $urandom_range(0, 5) == 0,
                    $urandom_range(0, 3) == 0, $urandom_range(0, 2) == 0, keep);
      end else if (pick <= 7) begin
         repeat ($urandom_range(1, 5)) send_tick();
      end else begin
         repeat ($urandom_range(1, 4))
            send_word(2'($urandom), 16'($urandom), 4'($urandom), 8'($urandom));
      end
   endtask

   // result checking on every accepted output word
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_result(rsp_bus.kind, rsp_bus.value, rsp_bus.register_index,
                         rsp_bus.status, rsp_bus.last);
   end

   // watchdog: too long without any handshake on any port means a hang
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready))
         stalled_cycles <= 0;
      else
         stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= IDLE_LIMIT) begin
         $display("modbus_rtu_register_read_master_top regression: fail");
         $finish;
      end
   end

   // receiver: random back-pressure, plus a long hold-off when asked for one
   initial begin : receiver
      int stall;
      rsp_bus.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (squeeze_pending) begin
            stall = SQUEEZE;
            squeeze_pending = 1'b0;
         end else begin
            stall = draw_idle(recv_calm);
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
      end
   end

   initial begin : stimulus
      int rand_start;
      bit second_squeeze;
      sb              = new();
      send_calm       = 0;
      recv_calm       = 0;
      words_counted   = 0;
      stalled_cycles  = 0;
      no_gaps         = 1'b0;
      squeeze_pending = 1'b0;
      second_squeeze  = 1'b0;
      req_bus.valid          <= 1'b0;
      req_bus.operation      <= OP_TICK;
      req_bus.start_address  <= '0;
      req_bus.register_count <= '0;
      req_bus.rx_byte        <= '0;
      csr_bus.valid          <= 1'b0;
      csr_bus.addr           <= CSR_SLAVE_ADDRESS;
      csr_bus.data           <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // words while nothing is awaited are ignored, as is an unknown operation
      send_tick();
      send_byte(SLAVE_ADDRESS_RST);
      send_word(OP_UNKNOWN, 16'($urandom), 4'($urandom), 8'($urandom));

      // top address with a zero count, taken as one register
      send_request(16'hFFFF, 4'd0);
      send_reply(1, 1'b0, 1'b0, 1'b0, -1);
      // count above the limit is clamped, ticks mixed into the reply
      send_request(16'h0000, 4'd15);
      send_reply(REG_LIMIT, 1'b0, 1'b0, 1'b1, -1);
      // bad crc gives a crc status word
      send_request(16'h1234, 4'(REG_LIMIT));
      send_reply(REG_LIMIT, 1'b1, 1'b0, 1'b0, -1);
      // wrong id bytes drop the frame before a good reply
      send_request(16'h8001, 4'd2);
      send_reply(2, 1'b0, 1'b1, 1'b0, -1);
      // request while a reply is half received abandons it
      send_request(16'h00FF, 4'd3);
      send_reply(3, 1'b0, 1'b0, 1'b0, 6);
      send_word(OP_UNKNOWN, 16'($urandom), 4'($urandom), 8'($urandom));
      send_request(16'hFF00, 4'd9);
      send_reply(REG_LIMIT, 1'b0, 1'b0, 1'b0, -1);

      // all-ones slave id, zero function code, short timeout
      configure(16'h00FF, 16'h0000, 16'd3);
      send_request(16'h5A5A, 4'd1);
      send_reply(1, 1'b0, 1'b0, 1'b0, -1);
      send_request(16'hA5A5, 4'd4);
      repeat (3) send_tick();
      send_tick();

      // zero timeout expires on the very first tick
      configure(16'h00FF, 16'h0000, 16'd0);
      send_request(16'h0001, 4'd5);
      send_tick();

      // longest timeout, ticks back to back, then a good reply
      configure(16'h0000, 16'h00FF, 16'hFFFF);
      send_request(16'h7FFF, 4'd1);
      no_gaps = 1'b1;
      repeat (8) send_tick();
      no_gaps = 1'b0;
      send_reply(1, 1'b0, 1'b0, 1'b1, -1);
      quiesce();
      write_csr(CSR_UNUSED, 16'($urandom));

      // random part: fresh settings per phase, receiver squeezed twice
      rand_start = words_counted;
      while (words_counted < rand_start + RAND_WORDS) begin
         if ($urandom_range(0, 3) == 0)
            configure(16'($urandom), 16'($urandom), 16'($urandom_range(1, 12)));
         else
            configure(16'($urandom), 16'($urandom), 16'($urandom_range(200, 65535)));
         if (words_counted == rand_start) squeeze_pending = 1'b1;
         if (!second_squeeze && words_counted >= rand_start + RAND_WORDS / 2) begin
            squeeze_pending = 1'b1;
            second_squeeze  = 1'b1;
         end
         repeat ($urandom_range(6, 10)) begin
            if (words_counted < rand_start + RAND_WORDS) random_sequence();
         end
      end

      quiesce();
      if (sb.failures == 0 && sb.expected_q.size() == 0)
         $display("modbus_rtu_register_read_master_top regression: pass");
      else
         $display("modbus_rtu_register_read_master_top regression: fail");
      $finish;
   end

endmodule

`default_nettype wire
